FILE: rtl/psh_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// psh_pkg
// Shared scan codes, event kinds and result types of the hotkey decoder.
// ----------------------------------------------------------------------------
package psh_pkg;

    localparam logic [7:0]  PFX_EXT   = 8'hE0;
    localparam logic [7:0]  PFX_BRK   = 8'hF0;

    localparam logic [15:0] KEY_LALT  = 16'h0011;
    localparam logic [15:0] KEY_RALT  = 16'hE011;
    localparam logic [15:0] KEY_LEFT  = 16'hE06B;
    localparam logic [15:0] KEY_RIGHT = 16'hE074;
    localparam logic [15:0] KEY_F1    = 16'h0005;
    localparam logic [15:0] KEY_F2    = 16'h0006;
    localparam logic [15:0] KEY_F3    = 16'h0004;
    localparam logic [15:0] KEY_F4    = 16'h000C;
    localparam logic [15:0] KEY_F5    = 16'h0003;
    localparam logic [15:0] KEY_F6    = 16'h000B;

    typedef logic [2:0] kind_t;

    localparam kind_t KIND_PRESS   = 3'd0;
    localparam kind_t KIND_RELEASE = 3'd1;
    localparam kind_t KIND_SWITCH  = 3'd2;
    localparam kind_t KIND_PREV    = 3'd3;
    localparam kind_t KIND_NEXT    = 3'd4;

    typedef struct packed {
        kind_t       kind;
        logic [15:0] code;
        logic [2:0]  con;
    } result_t;

    // count holds the number of valid entries (1 to 3), emitted res[0] first
    typedef struct packed {
        logic [1:0]    count;
        result_t [2:0] res;
    } burst_t;

endpackage
`default_nettype wire

FILE: rtl/psh_decode.sv
`default_nettype none
// ----------------------------------------------------------------------------
// psh_decode
// Prefix and Alt tracking; turns one byte into a burst of up to three results.
// ----------------------------------------------------------------------------
module psh_decode (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic [7:0]    data_byte,
    input  wire logic          fire,
    output logic               prefix,
    output psh_pkg::burst_t    burst
);
    import psh_pkg::*;

    logic        break_reg, break_next;
    logic        ext_reg, ext_next;
    logic        lalt_reg, lalt_next;
    logic        ralt_reg, ralt_next;
    logic [15:0] code;
    kind_t       hk_kind;
    logic [2:0]  hk_con;
    logic        hk_hit;
    logic        lalt_now, ralt_now;

    assign prefix = (data_byte == PFX_EXT) || (data_byte == PFX_BRK);
    assign code   = {(ext_reg ? PFX_EXT : 8'h00), data_byte};

    always_comb begin
        hk_kind = KIND_PRESS;
        hk_con  = 3'd0;
        hk_hit  = 1'b1;
        unique case (code)
            KEY_F1:    begin hk_kind = KIND_SWITCH; hk_con = 3'd0; end
            KEY_F2:    begin hk_kind = KIND_SWITCH; hk_con = 3'd1; end
            KEY_F3:    begin hk_kind = KIND_SWITCH; hk_con = 3'd2; end
            KEY_F4:    begin hk_kind = KIND_SWITCH; hk_con = 3'd3; end
            KEY_F5:    begin hk_kind = KIND_SWITCH; hk_con = 3'd4; end
            KEY_F6:    begin hk_kind = KIND_SWITCH; hk_con = 3'd5; end
            KEY_LEFT:  hk_kind = KIND_PREV;
            KEY_RIGHT: hk_kind = KIND_NEXT;
            default:   hk_hit = 1'b0;
        endcase
    end

    always_comb begin
        lalt_now = lalt_reg;
        ralt_now = ralt_reg;
        if (code == KEY_LALT) begin
            lalt_now = !break_reg;
        end
        if (code == KEY_RALT) begin
            ralt_now = !break_reg;
        end
    end

    always_comb begin
        burst = '0;
        burst.count = 2'd1;
        if (break_reg) begin
            burst.res[0] = '{kind: KIND_RELEASE, code: code, con: 3'd0};
        end else if (hk_hit && (lalt_now || ralt_now)) begin
            burst.res[0] = '{kind: hk_kind, code: 16'h0000, con: hk_con};
            burst.res[1] = '{kind: KIND_PRESS, code: (lalt_now ? KEY_LALT : KEY_RALT),
                             con: 3'd0};
            burst.res[2] = '{kind: KIND_PRESS, code: KEY_RALT, con: 3'd0};
            burst.count  = 2'd1 + {1'b0, lalt_now} + {1'b0, ralt_now};
        end else begin
            burst.res[0] = '{kind: KIND_PRESS, code: code, con: 3'd0};
        end
    end

    always_comb begin
        break_next = break_reg;
        ext_next   = ext_reg;
        lalt_next  = lalt_reg;
        ralt_next  = ralt_reg;
        if (fire) begin
            if (data_byte == PFX_EXT) begin
                ext_next = 1'b1;
            end else if (data_byte == PFX_BRK) begin
                break_next = 1'b1;
            end else begin
                break_next = 1'b0;
                ext_next   = 1'b0;
                lalt_next  = lalt_now;
                ralt_next  = ralt_now;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            break_reg <= 1'b0;
            ext_reg   <= 1'b0;
            lalt_reg  <= 1'b0;
            ralt_reg  <= 1'b0;
        end else begin
            break_reg <= break_next;
            ext_reg   <= ext_next;
            lalt_reg  <= lalt_next;
            ralt_reg  <= ralt_next;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/psh_emit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// psh_emit
// Burst and output registers; one result per cycle while m_ready is high.
// ----------------------------------------------------------------------------
module psh_emit (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire psh_pkg::burst_t burst_in,
    input  wire logic          load,
    output logic               take,
    output logic               m_valid,
    input  wire logic          m_ready,
    output logic [2:0]         m_event_kind,
    output logic [15:0]        m_key_code,
    output logic [2:0]         m_console_number,
    output logic               m_last
);
    import psh_pkg::*;

    burst_t      burst_reg;
    logic        burst_valid_reg;
    logic [1:0]  idx_reg;
    logic        m_valid_reg;
    result_t     m_res_reg;
    logic        m_last_reg;
    logic        out_free;
    logic        idx_last;
    result_t     cur;

    assign out_free = !m_valid_reg || m_ready;
    assign idx_last = (idx_reg == (burst_reg.count - 2'd1));
    assign take     = !burst_valid_reg || (out_free && idx_last);

    always_comb begin
        unique case (idx_reg)
            2'd0:    cur = burst_reg.res[0];
            2'd1:    cur = burst_reg.res[1];
            2'd2:    cur = burst_reg.res[2];
            default: cur = burst_reg.res[0];
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            burst_valid_reg <= 1'b0;
            idx_reg         <= 2'd0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (out_free) begin
                m_valid_reg <= burst_valid_reg;
            end
            if (load) begin
                burst_valid_reg <= 1'b1;
                idx_reg         <= 2'd0;
            end else if (out_free && burst_valid_reg) begin
                if (idx_last) begin
                    burst_valid_reg <= 1'b0;
                    idx_reg         <= 2'd0;
                end else begin
                    idx_reg <= idx_reg + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            burst_reg <= burst_in;
        end
        if (out_free && burst_valid_reg) begin
            m_res_reg  <= cur;
            m_last_reg <= idx_last;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_event_kind     = m_res_reg.kind;
    assign m_key_code       = m_res_reg.code;
    assign m_console_number = m_res_reg.con;
    assign m_last           = m_last_reg;

endmodule
`default_nettype wire

FILE: rtl/ps2_scancode_hotkey_decoder_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ps2_scancode_hotkey_decoder_top
// PS/2 scan code set 2 decoder with Alt console hotkeys.
//
// The s_ channel takes one raw keyboard byte per transaction (s_data_byte).
// Prefix bytes 0xE0 and 0xF0 produce no result; every other byte produces
// one to three results on the m_ channel, m_last marking the final one.
// Hotkeys (F1..F6, Left, Right while an Alt key is held) produce the hotkey
// event followed by press events for each held Alt key, left first.
//
// The first result of a byte passes through the input register, the burst
// register and the output register. The output register sends one result
// per cycle while m_ready is high; a prefix byte is consumed without a
// result. Input and output stages are decoupled, so the next byte is taken
// while earlier results are still being sent.
// Reset clears the prefix flags, the Alt state and all valid flags.
// When m_ready is low, the output holds and the stages behind it fill up
// before s_ready drops.
// ----------------------------------------------------------------------------
module ps2_scancode_hotkey_decoder_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_data_byte,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [2:0]       m_event_kind,
    output logic [15:0]      m_key_code,
    output logic [2:0]       m_console_number,
    output logic             m_last
);
    import psh_pkg::*;

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        prefix;
    logic        take;
    logic        consume;
    logic        load;
    burst_t      burst;

    assign consume = in_valid_reg && (prefix || take);
    assign load    = in_valid_reg && !prefix && take;
    assign s_ready = !in_valid_reg || consume;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (consume) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_data_byte;
        end
    end

    psh_decode u_decode (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .data_byte (in_byte_reg),
        .fire      (consume),
        .prefix    (prefix),
        .burst     (burst)
    );

    psh_emit u_emit (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .burst_in         (burst),
        .load             (load),
        .take             (take),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_event_kind     (m_event_kind),
        .m_key_code       (m_key_code),
        .m_console_number (m_console_number),
        .m_last           (m_last)
    );

endmodule
`default_nettype wire

FILE: dv/ps2_hotkey_event_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ps2_hotkey_event_checker
// Watches both channels of the hotkey decoder. Every accepted keyboard byte
// runs through a scan code predictor that keeps its own prefix and Alt state;
// the events it predicts are queued and each accepted result is compared
// field by field with the oldest one. Mismatches are counted for the top.
// ----------------------------------------------------------------------------
module ps2_hotkey_event_checker (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    input  wire logic        s_ready,
    input  wire logic [7:0]  s_data_byte,
    input  wire logic        m_valid,
    input  wire logic        m_ready,
    input  wire logic [2:0]  m_event_kind,
    input  wire logic [15:0] m_key_code,
    input  wire logic [2:0]  m_console_number,
    input  wire logic        m_last,
    output int               mismatch_count,
    output int               pending_results
);

    import psh_pkg::*;

    typedef struct packed {
        kind_t       kind;
        logic [15:0] code;
        logic [2:0]  con;
        logic        last;
    } key_event_t;

    key_event_t expected_events[$];
    key_event_t oldest;
    logic       release_armed;
    logic       extend_armed;
    logic       lalt_down;
    logic       ralt_down;

    initial begin
        mismatch_count  = 0;
        pending_results = 0;
    end

    function automatic key_event_t make_event(kind_t k, logic [15:0] c, logic [2:0] n);
        key_event_t ev;
        ev.kind = k;
        ev.code = c;
        ev.con  = n;
        ev.last = 1'b0;
        return ev;
    endfunction

    task automatic note_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("[%0t] MISMATCH %s", $realtime, what);
        end
    endtask

    task automatic decode_byte(input logic [7:0] b);
        key_event_t  evs [3];
        int          n;
        logic [15:0] code;
        kind_t       hot_kind;
        logic [2:0]  con;
        n        = 0;
        hot_kind = KIND_PRESS;
        con      = 3'd0;
        if (b == PFX_EXT) begin
            extend_armed = 1'b1;
        end else if (b == PFX_BRK) begin
            release_armed = 1'b1;
        end else begin
            code = {(extend_armed ? PFX_EXT : 8'h00), b};
            if (release_armed) begin
                if (code == KEY_LALT) lalt_down = 1'b0;
                if (code == KEY_RALT) ralt_down = 1'b0;
                evs[0] = make_event(KIND_RELEASE, code, 3'd0);
                n = 1;
            end else begin
                case (code)
                    KEY_F1: begin hot_kind = KIND_SWITCH; con = 3'd0; end
                    KEY_F2: begin hot_kind = KIND_SWITCH; con = 3'd1; end
                    KEY_F3: begin hot_kind = KIND_SWITCH; con = 3'd2; end
                    KEY_F4: begin hot_kind = KIND_SWITCH; con = 3'd3; end
                    KEY_F5: begin hot_kind = KIND_SWITCH; con = 3'd4; end
                    KEY_F6: begin hot_kind = KIND_SWITCH; con = 3'd5; end
                    KEY_LEFT: hot_kind = KIND_PREV;
                    KEY_RIGHT: hot_kind = KIND_NEXT;
                    default: hot_kind = KIND_PRESS;
                endcase
                if (code == KEY_LALT) lalt_down = 1'b1;
                if (code == KEY_RALT) ralt_down = 1'b1;
                if (hot_kind != KIND_PRESS && (lalt_down || ralt_down)) begin
                    evs[0] = make_event(hot_kind, 16'h0000, con);
                    n = 1;
                    if (lalt_down) begin
                        evs[n] = make_event(KIND_PRESS, KEY_LALT, 3'd0);
                        n++;
                    end
                    if (ralt_down) begin
                        evs[n] = make_event(KIND_PRESS, KEY_RALT, 3'd0);
                        n++;
                    end
                end else begin
                    evs[0] = make_event(KIND_PRESS, code, 3'd0);
                    n = 1;
                end
            end
            release_armed = 1'b0;
            extend_armed  = 1'b0;
            for (int i = 0; i < n; i++) begin
                evs[i].last = (i == n - 1);
                expected_events.push_back(evs[i]);
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            release_armed = 1'b0;
            extend_armed  = 1'b0;
            lalt_down     = 1'b0;
            ralt_down     = 1'b0;
            expected_events.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (expected_events.size() == 0) begin
                    note_mismatch($sformatf("unexpected transaction kind=%0d code=%h con=%0d last=%b",
                        m_event_kind, m_key_code, m_console_number, m_last));
                end else begin
                    oldest = expected_events.pop_front();
                    if (m_event_kind !== oldest.kind || m_key_code !== oldest.code ||
                        m_console_number !== oldest.con || m_last !== oldest.last) begin
                        note_mismatch($sformatf(
                            "exp kind=%0d code=%h con=%0d last=%b, got kind=%0d code=%h con=%0d last=%b",
                            oldest.kind, oldest.code, oldest.con, oldest.last,
                            m_event_kind, m_key_code, m_console_number, m_last));
                    end
                end
            end
            if (s_valid && s_ready) begin
                decode_byte(s_data_byte);
            end
        end
        pending_results = expected_events.size();
    end

endmodule

FILE: dv/ps2_scancode_hotkey_decoder_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ps2_scancode_hotkey_decoder_top_test
// Feeds the hotkey decoder with keyboard byte streams: a directed pass over
// prefixes, Alt handling and five hotkeys, then random key sequences that
// are mostly well formed, under three idling profiles on both channels.
// A separate checker predicts and compares; this top gives the verdict.
// ----------------------------------------------------------------------------
module ps2_scancode_hotkey_decoder_top_test;

    import psh_pkg::*;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_data_byte;
    logic        m_valid;
    logic        m_ready;
    logic [2:0]  m_event_kind;
    logic [15:0] m_key_code;
    logic [2:0]  m_console_number;
    logic        m_last;
    int          mismatch_count;
    int          pending_results;
    int          tx_idle_pct = 31;
    int          rx_idle_pct = 63;
    int          sent_bytes = 0;
    bit          paused_once = 1'b0;

    always #6 aclk = ~aclk;

    ps2_scancode_hotkey_decoder_top uut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_data_byte      (s_data_byte),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_event_kind     (m_event_kind),
        .m_key_code       (m_key_code),
        .m_console_number (m_console_number),
        .m_last           (m_last)
    );

    ps2_hotkey_event_checker checker_i (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_data_byte      (s_data_byte),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_event_kind     (m_event_kind),
        .m_key_code       (m_key_code),
        .m_console_number (m_console_number),
        .m_last           (m_last),
        .mismatch_count   (mismatch_count),
        .pending_results  (pending_results)
    );

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    initial begin
        #3_000_000;
        $display("Some tests failed");
        $finish;
    end

    task automatic send_byte(input logic [7:0] b);
        @(negedge aclk);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_data_byte <= b;
        do @(posedge aclk); while (!s_ready);
        sent_bytes++;
    endtask

    task automatic send_key(input logic [15:0] code, input logic release_key);
        if (code[15:8] == PFX_EXT && release_key && $urandom_range(1) == 1) begin
            send_byte(PFX_EXT);
            send_byte(PFX_BRK);
        end else begin
            if (code[15:8] == PFX_EXT) send_byte(PFX_EXT);
            if (release_key) send_byte(PFX_BRK);
        end
        send_byte(code[7:0]);
    endtask

    task automatic drain_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        wait (pending_results == 0);
    endtask

    function automatic logic [15:0] pick_hotkey();
        case ($urandom_range(7))
            0: return KEY_F1;
            1: return KEY_F2;
            2: return KEY_F3;
            3: return KEY_F4;
            4: return KEY_F5;
            5: return KEY_F6;
            6: return KEY_LEFT;
            default: return KEY_RIGHT;
        endcase
    endfunction

    function automatic logic [7:0] pick_key_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(255)); while (b == PFX_EXT || b == PFX_BRK);
        return b;
    endfunction

    task automatic send_random_sequence();
        int r;
        r = $urandom_range(99);
        if (r < 25) begin
            send_key(pick_hotkey(), 1'b0);
        end else if (r < 40) begin
            send_key($urandom_range(1) ? KEY_LALT : KEY_RALT, 1'b0);
        end else if (r < 52) begin
            send_key($urandom_range(1) ? KEY_LALT : KEY_RALT, 1'b1);
        end else if (r < 62) begin
            send_key(pick_hotkey(), 1'b1);
        end else if (r < 82) begin
            send_key({($urandom_range(1) ? PFX_EXT : 8'h00), pick_key_byte()},
                     1'($urandom_range(1)));
        end else begin
            send_byte(8'($urandom_range(255)));
        end
    endtask

    initial begin
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_data_byte = 8'h00;
        m_ready     = 1'b0;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        send_byte(8'h00);
        send_byte(8'hFF);
        send_key(KEY_F1, 1'b0);
        send_key(KEY_LEFT, 1'b0);
        send_byte(PFX_EXT);
        send_byte(PFX_EXT);
        send_byte(KEY_F1[7:0]);
        send_key(KEY_LALT, 1'b0);
        send_key(KEY_LALT, 1'b0);
        send_key(KEY_F1, 1'b0);
        send_key(KEY_RALT, 1'b0);
        send_key(KEY_F4, 1'b0);
        send_key(KEY_RIGHT, 1'b0);
        send_key(KEY_LEFT, 1'b0);
        send_key(KEY_F1, 1'b1);
        send_key(KEY_LALT, 1'b1);
        send_key(KEY_F6, 1'b0);
        send_byte(PFX_EXT);
        send_byte(PFX_BRK);
        send_byte(KEY_RALT[7:0]);
        send_byte(PFX_BRK);
        send_byte(PFX_BRK);
        send_byte(KEY_LALT[7:0]);
        send_key(KEY_F6, 1'b0);

        while (sent_bytes < 120) send_random_sequence();

        tx_idle_pct = 63;
        rx_idle_pct = 31;
        while (sent_bytes < 215) begin
            send_random_sequence();
            if (!paused_once && sent_bytes >= 165) begin
                drain_results();
                paused_once = 1'b1;
            end
        end

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        while (sent_bytes < 310) send_random_sequence();

        drain_results();
        repeat (20) @(posedge aclk);
        if (mismatch_count == 0 && pending_results == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/psh_pkg.sv
rtl/psh_decode.sv
rtl/psh_emit.sv
rtl/ps2_scancode_hotkey_decoder_top.sv
dv/ps2_hotkey_event_checker.sv
dv/ps2_scancode_hotkey_decoder_top_test.sv
